// ===== rtl/sfe_pkg.sv =====
`default_nettype none

package sfe_pkg;

    localparam int unsigned C_SLOTS     = 10;
    localparam int unsigned C_SLOT_W    = 4;
    localparam int unsigned C_SUM_W     = 12;

    // slot layout: header 0..2, data group 3..6, trailer 7..9
    localparam logic [C_SLOT_W-1:0] C_SLOT_CR = 4'd9;

    localparam logic [7:0] C_HASH    = 8'h23;  // '#'
    localparam logic [7:0] C_LOWER_A = 8'h61;  // 'a'
    localparam logic [7:0] C_EQ      = 8'h3D;  // '='
    localparam logic [7:0] C_CR      = 8'h0D;  // '\r'
    localparam logic [5:0] C_SIX_MSK = 6'h3F;

    typedef logic [C_SLOTS-1:0]      t_mask;
    typedef logic [C_SLOTS-1:0][7:0] t_chars;

    // everything one input item produces, plus the encoder state after it
    typedef struct packed {
        t_mask              mask;
        t_chars             chars;
        logic [C_SUM_W-1:0] sum;
        logic [15:0]        held;
        logic [1:0]         cnt;
    } t_build;

    function automatic logic [7:0] f_b64(input logic [5:0] six);
        f_b64 = C_EQ + {2'b00, six & C_SIX_MSK};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sfe_build.sv =====
`default_nettype none

module sfe_build
    import sfe_pkg::*;
(
    input  wire logic               i_first,
    input  wire logic [7:0]         i_addr,
    input  wire logic [7:0]         i_command_byte,
    input  wire logic               i_payload_valid,
    input  wire logic [7:0]         i_payload_byte,
    input  wire logic               i_last,
    input  wire logic [C_SUM_W-1:0] i_sum,
    input  wire logic [15:0]        i_held,
    input  wire logic [1:0]         i_cnt,
    output t_build                  o_build
);

    logic [C_SUM_W-1:0] w_sum0;
    logic [15:0]        w_hb0;
    logic [1:0]         w_cnt0;
    logic [15:0]        w_hb1;
    logic [1:0]         w_cnt1;
    logic [7:0]         w_hdr1;
    logic               w_grp;
    logic [7:0]         w_ga, w_gb, w_gc;
    logic [7:0]         w_g0, w_g1, w_g2, w_g3;
    logic [C_SUM_W-1:0] w_hsum, w_gsum, w_sum;

    always_comb begin
        // a new frame drops any partial group and the running sum
        w_sum0 = i_first ? '0 : i_sum;
        w_hb0  = i_first ? '0 : i_held;
        w_cnt0 = i_first ? '0 : i_cnt;

        w_hb1  = w_hb0;
        w_cnt1 = w_cnt0;
        w_grp  = 1'b0;
        w_ga   = '0;
        w_gb   = '0;
        w_gc   = '0;
        if (i_payload_valid) begin
            unique case (w_cnt0)
                2'd0: begin
                    w_hb1  = {8'h00, i_payload_byte};
                    w_cnt1 = 2'd1;
                end
                2'd1: begin
                    w_hb1  = {w_hb0[7:0], i_payload_byte};
                    w_cnt1 = 2'd2;
                end
                default: begin
                    w_grp  = 1'b1;
                    w_ga   = w_hb0[15:8];
                    w_gb   = w_hb0[7:0];
                    w_gc   = i_payload_byte;
                    w_hb1  = '0;
                    w_cnt1 = 2'd0;
                end
            endcase
        end
        // flush a partial group, zero padded
        if (i_last && (w_cnt1 != 2'd0)) begin
            w_grp = 1'b1;
            w_ga  = (w_cnt1 == 2'd1) ? w_hb1[7:0] : w_hb1[15:8];
            w_gb  = (w_cnt1 == 2'd1) ? 8'h00 : w_hb1[7:0];
            w_gc  = 8'h00;
        end

        w_hdr1 = C_LOWER_A + i_addr;
        w_g0   = f_b64(w_ga[7:2]);
        w_g1   = f_b64({w_ga[1:0], w_gb[7:4]});
        w_g2   = f_b64({w_gb[3:0], w_gc[7:6]});
        w_g3   = f_b64(w_gc[5:0]);

        w_hsum = i_first ? ({4'h0, C_HASH} + {4'h0, w_hdr1} + {4'h0, i_command_byte}) : '0;
        w_gsum = w_grp ? ({4'h0, w_g0} + {4'h0, w_g1} + {4'h0, w_g2} + {4'h0, w_g3}) : '0;
        w_sum  = w_sum0 + w_hsum + w_gsum;

        o_build.chars = {C_CR, f_b64(w_sum[5:0]), f_b64(w_sum[11:6]),
                         w_g3, w_g2, w_g1, w_g0,
                         i_command_byte, w_hdr1, C_HASH};
        o_build.mask  = {{3{i_last}}, {4{w_grp}}, {3{i_first}}};
        o_build.sum   = i_last ? '0 : w_sum;
        o_build.held  = i_last ? '0 : w_hb1;
        o_build.cnt   = i_last ? '0 : w_cnt1;
    end

endmodule

`default_nettype wire

// ===== rtl/serial_frame_encoder.sv =====
// Serial frame encoder: turns a stream of frame items into ASCII characters.
// Input channel (i_valid / o_ready): one transfer per item carrying first,
// addr, command_byte, payload_valid, payload_byte and last.
// Output channel (o_valid / i_ready): one transfer per character, with
// o_run_end on the last character of an item and o_frame_end on the '\r'.
// An accepted item is encoded in a single pass into a ten-slot character
// buffer (header, data group, trailer) plus the updated checksum and held
// bytes. The first character is offered the cycle after the transfer.
// Throughput: the output port moves one character per cycle while i_ready
// is high, so an item that yields k characters holds the buffer until all k have left;
// the next item with characters is taken in the cycle the buffer's last character leaves.
// Items that yield no character are taken every cycle, even while the
// buffer drains, since they only update the held bytes.
// A stalled receiver (i_ready low) holds the current character; the block
// then takes no item that yields characters.
// Reset (i_rst_n low, synchronous) empties the buffer and clears the
// checksum and the held group.
`default_nettype none

module serial_frame_encoder
    import sfe_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_first,
    input  wire logic [7:0] i_addr,
    input  wire logic [7:0] i_command_byte,
    input  wire logic       i_payload_valid,
    input  wire logic [7:0] i_payload_byte,
    input  wire logic       i_last,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_run_end,
    output logic            o_frame_end
);

    // encoder state
    logic [C_SUM_W-1:0] r_sum;
    logic [15:0]        r_held;
    logic [1:0]         r_cnt;
    // character buffer: pending slots and their characters
    t_mask              r_mask, n_mask;
    t_chars             r_chars;

    t_build             w_build;
    t_mask              w_rest;
    logic [C_SLOT_W-1:0] w_idx;
    logic               w_in_xfer;
    logic               w_out_xfer;
    logic               w_one_left;
    logic               w_loads;

    sfe_build u_build (
        .i_first        (i_first),
        .i_addr         (i_addr),
        .i_command_byte (i_command_byte),
        .i_payload_valid(i_payload_valid),
        .i_payload_byte (i_payload_byte),
        .i_last         (i_last),
        .i_sum          (r_sum),
        .i_held         (r_held),
        .i_cnt          (r_cnt),
        .o_build        (w_build)
    );

    // lowest pending slot goes out first
    always_comb begin
        w_idx = '0;
        for (int i = C_SLOTS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                w_idx = C_SLOT_W'(i);
            end
        end
    end

    assign w_rest     = r_mask & (r_mask - t_mask'(1));
    assign w_one_left = (w_rest == '0);
    assign w_loads    = (w_build.mask != '0);

    assign o_valid     = (r_mask != '0);
    assign o_out_byte  = r_chars[w_idx];
    assign o_run_end   = w_one_left;
    assign o_frame_end = (w_idx == C_SLOT_CR);

    assign o_ready    = !w_loads || !o_valid || (i_ready && w_one_left);
    assign w_in_xfer  = i_valid && o_ready;
    assign w_out_xfer = o_valid && i_ready;

    always_comb begin
        n_mask = w_out_xfer ? w_rest : r_mask;
        if (w_in_xfer && w_loads) begin
            n_mask = w_build.mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_sum  <= '0;
            r_held <= '0;
            r_cnt  <= '0;
        end else begin
            r_mask <= n_mask;
            if (w_in_xfer) begin
                r_sum  <= w_build.sum;
                r_held <= w_build.held;
                r_cnt  <= w_build.cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer && w_loads) begin
            r_chars <= w_build.chars;
        end
    end

    // a new item never overwrites characters still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && w_loads) |-> (!o_valid || (w_out_xfer && w_one_left)))
        else $error("buffer overwritten while characters pending");

    // the group counter never reaches three
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("held count out of range");

    // the carriage return is always the item's last character
    a_cr_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_end) |-> o_run_end)
        else $error("frame end without run end");

    // a frame's end leaves the encoder with nothing held
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_last) |=> (r_cnt == 2'd0 && r_sum == '0))
        else $error("state not cleared after last");

    // nothing offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sfe_pkg::*;

    // one input item as it crosses the input channel
    typedef struct packed {
        logic       first;
        logic [7:0] addr;
        logic [7:0] command_byte;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       last;
    } t_frame_item;

    // one encoded character as it crosses the output channel
    typedef struct packed {
        logic [7:0] ch;
        logic       run_end;
        logic       frame_end;
    } t_enc_char;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic       i_first;
    logic [7:0] i_addr;
    logic [7:0] i_command_byte;
    logic       i_payload_valid;
    logic [7:0] i_payload_byte;
    logic       i_last;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_run_end;
    logic       o_frame_end;

    serial_frame_encoder u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_first         (i_first),
        .i_addr          (i_addr),
        .i_command_byte  (i_command_byte),
        .i_payload_valid (i_payload_valid),
        .i_payload_byte  (i_payload_byte),
        .i_last          (i_last),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_byte      (o_out_byte),
        .o_run_end       (o_run_end),
        .o_frame_end     (o_frame_end)
    );

    always #10 i_clk = ~i_clk;

    // Encoder state mirrored by the predictor
    logic [11:0] frame_sum;
    logic [15:0] held_pair;
    logic [1:0]  held_count;

    // characters produced by the item being predicted
    t_enc_char   item_chars [10];
    int          item_nchars;

    t_enc_char   expected_chars [$];
    int          mismatches;
    int          items_sent;
    bit          calm;       // no idling on either side while set
    int          stall_left = 0;

    // --------------------------------------------------------------
    // Predictor
    // --------------------------------------------------------------

    // Append one character; header and data characters feed the checksum,
    // trailer characters do not.
    function automatic void put_char(logic [7:0] ch, bit summed, bit fend);
        item_chars[item_nchars] = '{ch: ch, run_end: 1'b0, frame_end: fend};
        item_nchars++;
        if (summed)
            frame_sum = frame_sum + {4'd0, ch};
    endfunction

    // 24-bit group split into four six-bit characters, MSBs first
    function automatic void put_group(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        put_char(C_EQ + {2'b00, a[7:2]}, 1'b1, 1'b0);
        put_char(C_EQ + {2'b00, a[1:0], b[7:4]}, 1'b1, 1'b0);
        put_char(C_EQ + {2'b00, b[3:0], c[7:6]}, 1'b1, 1'b0);
        put_char(C_EQ + {2'b00, c[5:0]}, 1'b1, 1'b0);
    endfunction

    // Updates the mirrored state for one accepted item and queues the
    // characters it must produce: header, then data, then trailer.
    function automatic void encode_item(t_frame_item it);
        int k;
        item_nchars = 0;
        if (it.first) begin
            // a new frame drops any partial group and restarts the sum
            frame_sum  = '0;
            held_pair  = '0;
            held_count = '0;
            put_char(C_HASH, 1'b1, 1'b0);
            put_char(C_LOWER_A + it.addr, 1'b1, 1'b0);
            put_char(it.command_byte, 1'b1, 1'b0);
        end
        if (it.payload_valid) begin
            case (held_count)
                2'd0: begin
                    held_pair  = {8'd0, it.payload_byte};
                    held_count = 2'd1;
                end
                2'd1: begin
                    held_pair  = {held_pair[7:0], it.payload_byte};
                    held_count = 2'd2;
                end
                default: begin
                    put_group(held_pair[15:8], held_pair[7:0], it.payload_byte);
                    held_pair  = '0;
                    held_count = '0;
                end
            endcase
        end
        if (it.last) begin
            // flush a partial group zero padded, then checksum and CR
            if (held_count == 2'd1)
                put_group(held_pair[7:0], 8'd0, 8'd0);
            else if (held_count >= 2'd2)
                put_group(held_pair[15:8], held_pair[7:0], 8'd0);
            put_char(C_EQ + {2'b00, frame_sum[11:6]}, 1'b0, 1'b0);
            put_char(C_EQ + {2'b00, frame_sum[5:0]}, 1'b0, 1'b0);
            put_char(C_CR, 1'b0, 1'b1);
            frame_sum  = '0;
            held_pair  = '0;
            held_count = '0;
        end
        if (item_nchars > 0)
            item_chars[item_nchars-1].run_end = 1'b1;
        for (k = 0; k < item_nchars; k++)
            expected_chars.push_back(item_chars[k]);
    endfunction

    // --------------------------------------------------------------
    // Stimulus helpers
    // --------------------------------------------------------------

    // idle length: mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(4, 20);
        return $urandom_range(1, 3);
    endfunction

    function automatic t_frame_item mk_item(logic first, logic [7:0] addr,
                                            logic [7:0] cmd, logic pvalid,
                                            logic [7:0] pbyte, logic last);
        return '{first: first, addr: addr, command_byte: cmd,
                 payload_valid: pvalid, payload_byte: pbyte, last: last};
    endfunction

    // fully random item; flags set with modest odds
    function automatic t_frame_item random_item();
        t_frame_item it;
        it.first         = ($urandom_range(0, 5) == 0);
        it.addr          = 8'($urandom);
        it.command_byte  = 8'($urandom);
        it.payload_valid = 1'($urandom_range(0, 1));
        it.payload_byte  = 8'($urandom);
        it.last          = ($urandom_range(0, 5) == 0);
        return it;
    endfunction

    // Presents one item and holds it until the transfer; the prediction is
    // made at the accepting edge. Valid stays high when no gap follows.
    task automatic send_item(t_frame_item it);
        int gap;
        i_valid         <= 1'b1;
        i_first         <= it.first;
        i_addr          <= it.addr;
        i_command_byte  <= it.command_byte;
        i_payload_valid <= it.payload_valid;
        i_payload_byte  <= it.payload_byte;
        i_last          <= it.last;
        do
            @(posedge i_clk);
        while (o_ready !== 1'b1);
        encode_item(it);
        items_sent++;
        gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // A frame with random content. Most are well formed; a few lack the
    // opening or closing item so the block runs on without a header or has
    // a partial group discarded by the next frame start.
    task automatic send_frame();
        t_frame_item it;
        int          nbytes;
        bit          skip_first;
        bit          skip_last;
        bit          close_data;
        nbytes     = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                  : $urandom_range(0, 8);
        skip_first = ($urandom_range(0, 11) == 0);
        skip_last  = ($urandom_range(0, 11) == 0);
        if (!skip_first) begin
            it               = random_item();
            it.first         = 1'b1;
            it.last          = 1'b0;
            it.payload_valid = (nbytes > 0) && $urandom_range(0, 1);
            if (it.payload_valid)
                nbytes--;
            send_item(it);
        end
        close_data = (nbytes > 0) && $urandom_range(0, 1);
        if (close_data)
            nbytes--;
        while (nbytes > 0) begin
            it               = random_item();
            it.first         = 1'b0;
            it.last          = 1'b0;
            it.payload_valid = ($urandom_range(0, 9) != 0);
            if (it.payload_valid)
                nbytes--;
            send_item(it);
        end
        if (!skip_last) begin
            it               = random_item();
            it.first         = 1'b0;
            it.last          = 1'b1;
            it.payload_valid = close_data;
            send_item(it);
        end
    endtask

    // --------------------------------------------------------------
    // Tests
    // --------------------------------------------------------------

    // Extremes and the corner cases of the frame format
    task automatic test_directed();
        // nothing to send: no characters, state untouched
        send_item(mk_item(1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0));
        // data and close with no frame ever opened since reset
        send_item(mk_item(1'b0, 8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0));
        send_item(mk_item(1'b0, 8'h00, 8'h00, 1'b0, 8'hFF, 1'b1));
        // empty frame: header, then checksum and CR only
        send_item(mk_item(1'b1, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0));
        send_item(mk_item(1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1));
        // open, one byte and close in a single item: the longest run,
        // address wraps past 0xFF
        send_item(mk_item(1'b1, 8'hFF, 8'hFF, 1'b1, 8'hFF, 1'b1));
        // full group, then a partial group of one flushed at close
        send_item(mk_item(1'b1, 8'h80, 8'h41, 1'b0, 8'h00, 1'b0));
        send_item(mk_item(1'b0, 8'h00, 8'h00, 1'b1, 8'hFF, 1'b0));
        send_item(mk_item(1'b0, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0));
        send_item(mk_item(1'b0, 8'h00, 8'h00, 1'b1, 8'hFF, 1'b0));
        send_item(mk_item(1'b0, 8'h00, 8'h00, 1'b1, 8'hAA, 1'b0));
        send_item(mk_item(1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1));
        // partial group of two flushed at close
        send_item(mk_item(1'b1, 8'h9E, 8'h7F, 1'b1, 8'h12, 1'b0));
        send_item(mk_item(1'b0, 8'h00, 8'h00, 1'b1, 8'h34, 1'b0));
        send_item(mk_item(1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1));
        // third byte arrives with close: full group then trailer
        send_item(mk_item(1'b1, 8'h01, 8'h80, 1'b1, 8'hF0, 1'b0));
        send_item(mk_item(1'b0, 8'h00, 8'h00, 1'b1, 8'h0F, 1'b0));
        send_item(mk_item(1'b0, 8'h00, 8'h00, 1'b1, 8'hC3, 1'b1));
        // new frame while a group is partial: held bytes are dropped
        send_item(mk_item(1'b1, 8'h10, 8'h55, 1'b1, 8'h55, 1'b0));
        send_item(mk_item(1'b1, 8'h1F, 8'hAA, 1'b0, 8'h00, 1'b0));
        // byte present but not flagged valid is ignored
        send_item(mk_item(1'b0, 8'h00, 8'h00, 1'b0, 8'hA5, 1'b0));
        send_item(mk_item(1'b0, 8'h00, 8'h00, 1'b1, 8'h3C, 1'b0));
        send_item(mk_item(1'b0, 8'h00, 8'h00, 1'b0, 8'hFF, 1'b1));
        // open and close together with no data
        send_item(mk_item(1'b1, 8'h7F, 8'h01, 1'b0, 8'h00, 1'b1));
    endtask

    // Random frames back to back with both sides always ready
    task automatic test_back_to_back(int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        calm    = 1'b1;
        while (items_sent < stop_at)
            send_frame();
        calm    = 1'b0;
    endtask

    // Random frames with idling on both sides
    task automatic test_random_frames(int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
            send_frame();
    endtask

    // Unstructured items: stray opens, closes and data in any mix
    task automatic test_noise(int n_items);
        repeat (n_items)
            send_item(random_item());
    endtask

    // --------------------------------------------------------------
    // Receiver side: random stalls unless in a calm stretch
    // --------------------------------------------------------------
    always @(posedge i_clk) begin
        if (calm) begin
            i_ready    <= 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left--;
        end else begin
            i_ready    <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = idle_len();
        end
    end

    // --------------------------------------------------------------
    // Result check: every output transfer against the oldest expectation
    // --------------------------------------------------------------
    always @(posedge i_clk) begin : check_chars
        t_enc_char want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (expected_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected character %h run_end %b frame_end %b",
                             $realtime, o_out_byte, o_run_end, o_frame_end);
            end else begin
                want = expected_chars.pop_front();
                if (o_out_byte !== want.ch || o_run_end !== want.run_end ||
                    o_frame_end !== want.frame_end) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("%0t: character mismatch: expected byte %h ",
                               $realtime, want.ch);
                        $write("run_end %b frame_end %b, ",
                               want.run_end, want.frame_end);
                        $display("got byte %h run_end %b frame_end %b",
                                 o_out_byte, o_run_end, o_frame_end);
                    end
                end
            end
        end
    end

    // --------------------------------------------------------------
    // Main sequence
    // --------------------------------------------------------------
    initial begin
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_first         <= 1'b0;
        i_addr          <= '0;
        i_command_byte  <= '0;
        i_payload_valid <= 1'b0;
        i_payload_byte  <= '0;
        i_last          <= 1'b0;
        frame_sum       = '0;
        held_pair       = '0;
        held_count      = '0;
        mismatches      = 0;
        items_sent      = 0;
        calm            = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_back_to_back(40);
        test_random_frames(110);
        test_noise(30);
        test_random_frames(25);

        // stimulus done: drain, then allow the pipeline to settle
        i_valid <= 1'b0;
        while (expected_chars.size() > 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (mismatches == 0)
            $display("serial_frame_encoder verification clean");
        else
            $display("serial_frame_encoder verification failed");
        $finish;
    end

    // watchdog: several times the slowest legal run
    initial begin
        #5ms;
        $display("serial_frame_encoder verification failed");
        $finish;
    end

endmodule

`default_nettype wire
